// ===== hdl/mcca_pkg.sv =====
// Shared types, constants and codes for the cache color allocator.
package mcca_pkg;

    localparam int MAX_COLORS  = 256;
    localparam int NUM_CLIENTS = 8;

    localparam int LG_W   = 4;    // width of a log2 color count
    localparam int CFG_AW = 2;    // register index width
    localparam int CFG_DW = 4;    // widest register

    localparam logic [CFG_AW-1:0] REG_LEVELS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_LG1    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_LG2    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_LG3    = 2'd3;

    localparam logic [1:0] KIND_ALLOC_ANY  = 2'd0;
    localparam logic [1:0] KIND_ALLOC_SPEC = 2'd1;
    localparam logic [1:0] KIND_FREE_ANY   = 2'd2;
    localparam logic [1:0] KIND_FREE_SPEC  = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_NOTHING = 2'd2
    } t_status;

    // Which map and which index an access uses.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_FREE_C,       // free map of the request level, at color
        ACC_FREE_FINE,    // free map of level t, finer range word j
        ACC_FREE_COARSE,  // free map of level t, covering bit
        ACC_LVL_RANGE,    // free map of the request level, range under t's bit
        ACC_OWN           // client map, last-level range word j
    } t_acc;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK,
        S_AA_RD, S_AA_EV, S_AS_RD, S_AS_EV,
        S_FA_RD, S_FA_EV, S_FS_RD, S_FS_EV,
        S_OWN_RD, S_OWN_EV,
        S_TK_LVL, S_TK_OWN,
        S_GV_LVL, S_GV_CHK_RD, S_GV_CHK_EV, S_GV_SET, S_GV_OWN
    } t_state;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    c_zero;
        logic    c_color;
        logic    c_inc;
        logic    t_first_take;
        logic    t_first_give;
        logic    t_inc;
        logic    t_dec;
        logic    j_clr;
        logic    j_inc;
        t_acc    acc;
        logic    wr;
        logic    wdata;
        logic    res_set;
        t_status res_code;
    } t_dp_cmd;

    typedef struct packed {
        logic       rd_bit;
        logic       bad;
        logic       oob;
        logic       c_last;
        logic       j_last_fine;
        logic       j_last_coarse;
        logic       j_last_own;
        logic       t_coarse;
        logic       t_zero;
        logic       t_top;
        logic       sweep_last;
        logic [1:0] kind;
    } t_dp_stat;

endpackage

// ===== hdl/mcca_dp.sv =====
// Datapath: config registers, color maps, counters and result register.
module mcca_dp #(
    parameter int MAX_COLORS  = mcca_pkg::MAX_COLORS,
    parameter int NUM_CLIENTS = mcca_pkg::NUM_CLIENTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mcca_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [mcca_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic [1:0]                  i_kind,
    input  logic [1:0]                  i_level,
    input  logic [7:0]                  i_color,
    input  logic [2:0]                  i_client,
    input  mcca_pkg::t_dp_cmd           i_cmd,
    output mcca_pkg::t_dp_stat          o_stat,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_chosen_color
);
    localparam int LM    = $clog2(MAX_COLORS + 1) - 1;          // floor log2
    localparam int CLW   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int OAW   = CLW + LM;
    localparam int FDEP  = 2 ** LM;
    localparam int ODEP  = 2 ** OAW;
    localparam logic [mcca_pkg::LG_W-1:0] LG_MAX = mcca_pkg::LG_W'(LM);

    // config
    logic [1:0]                  r_levels;
    logic [mcca_pkg::LG_W-1:0]   r_lg_raw [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= 2'd3;
            r_lg_raw[0] <= 4'd3;
            r_lg_raw[1] <= 4'd5;
            r_lg_raw[2] <= 4'd7;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcca_pkg::REG_LEVELS: r_levels    <= i_cfg_data[1:0];
                mcca_pkg::REG_LG1:    r_lg_raw[0] <= i_cfg_data;
                mcca_pkg::REG_LG2:    r_lg_raw[1] <= i_cfg_data;
                mcca_pkg::REG_LG3:    r_lg_raw[2] <= i_cfg_data;
            endcase
        end
    end

    // derived level sizes
    logic [1:0]                nlev;
    logic [mcca_pkg::LG_W-1:0] lg_sat [3];
    logic [mcca_pkg::LG_W-1:0] lg     [3];
    logic [mcca_pkg::LG_W-1:0] lg_last;

    always_comb begin
        nlev = (r_levels == 2'd0) ? 2'd1 : r_levels;
        for (int i = 0; i < 3; i++)
            lg_sat[i] = (r_lg_raw[i] > LG_MAX) ? LG_MAX : r_lg_raw[i];
        unique case (nlev)
            2'd1:    lg_last = lg_sat[0];
            2'd2:    lg_last = lg_sat[1];
            default: lg_last = lg_sat[2];
        endcase
        for (int i = 0; i < 3; i++)
            lg[i] = (2'(i) + 2'd1 < nlev && lg_sat[i] > lg_last) ? lg_last : lg_sat[i];
    end

    // operation registers
    logic [1:0]    r_kind, r_lvl, r_t;
    logic [7:0]    r_color;
    logic [2:0]    r_client;
    logic [LM-1:0] r_c, r_j;
    logic [OAW-1:0] r_sweep;

    function automatic logic [LM-1:0] lo_mask(input logic [mcca_pkg::LG_W-1:0] sh);
        lo_mask = ~({LM{1'b1}} << sh);
    endfunction

    function automatic logic [mcca_pkg::LG_W-1:0] lg_at(input logic [1:0] idx,
        input logic [mcca_pkg::LG_W-1:0] l0, input logic [mcca_pkg::LG_W-1:0] l1,
        input logic [mcca_pkg::LG_W-1:0] l2);
        unique case (idx)
            2'd0:    lg_at = l0;
            2'd1:    lg_at = l1;
            default: lg_at = l2;
        endcase
    endfunction

    logic [mcca_pkg::LG_W-1:0] lg_l, lg_t, sh_fine, sh_coarse, sh_own;
    logic [LM-1:0]  a_fine, a_coarse, a_range, a_own, color_c;
    logic [LM+7:0]  color_ext;
    logic [CLW+2:0] client_ext;
    logic [CLW-1:0] cl;

    assign lg_l      = lg_at(r_lvl, lg[0], lg[1], lg[2]);
    assign lg_t      = lg_at(r_t, lg[0], lg[1], lg[2]);
    assign sh_fine   = lg_t - lg_l;
    assign sh_coarse = lg_l - lg_t;
    assign sh_own    = lg_last - lg_l;
    assign a_fine    = (r_c << sh_fine) | r_j;
    assign a_coarse  = r_c >> sh_coarse;
    assign a_range   = (a_coarse << sh_coarse) | r_j;
    assign a_own     = (r_c << sh_own) | r_j;
    assign color_ext = {LM'(0), r_color};
    assign color_c   = color_ext[LM-1:0];
    assign client_ext = {CLW'(0), r_client};
    assign cl        = client_ext[CLW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cfg_we) begin
            r_sweep <= '0;
        end else if (i_cmd.clr_step) begin
            r_sweep <= r_sweep + OAW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_lvl    <= i_level;
            r_color  <= i_color;
            r_client <= i_client;
        end
        if (i_cmd.c_zero)       r_c <= '0;
        else if (i_cmd.c_color) r_c <= color_c;
        else if (i_cmd.c_inc)   r_c <= r_c + LM'(1);
        if (i_cmd.t_first_take)      r_t <= 2'd0;
        else if (i_cmd.t_first_give) r_t <= nlev - 2'd1;
        else if (i_cmd.t_inc)        r_t <= r_t + 2'd1;
        else if (i_cmd.t_dec)        r_t <= r_t - 2'd1;
        if (i_cmd.j_clr)      r_j <= '0;
        else if (i_cmd.j_inc) r_j <= r_j + LM'(1);
    end

    // free maps, one memory per level
    logic [LM-1:0] free_addr;
    logic [2:0]    r_free_q;

    always_comb begin
        unique case (i_cmd.acc)
            mcca_pkg::ACC_FREE_FINE:   free_addr = a_fine;
            mcca_pkg::ACC_FREE_COARSE: free_addr = a_coarse;
            mcca_pkg::ACC_LVL_RANGE:   free_addr = a_range;
            default:                   free_addr = r_c;
        endcase
        if (i_cmd.clr_step) free_addr = r_sweep[LM-1:0];
    end

    for (genvar g = 0; g < 3; g++) begin : g_free
        logic r_mem [FDEP];
        logic we;
        assign we = i_cmd.clr_step || (i_cmd.wr && r_t == 2'(g) &&
                    (i_cmd.acc == mcca_pkg::ACC_FREE_FINE ||
                     i_cmd.acc == mcca_pkg::ACC_FREE_COARSE));
        always_ff @(posedge i_clk) begin
            if (we) r_mem[free_addr] <= i_cmd.clr_step | i_cmd.wdata;
            r_free_q[g] <= r_mem[free_addr];
        end
    end

    // client ownership map
    logic           r_own_mem [ODEP];
    logic           r_own_q, r_rd_own, own_we;
    logic [OAW-1:0] own_addr;

    assign own_addr = i_cmd.clr_step ? r_sweep : {cl, a_own};
    assign own_we   = i_cmd.clr_step || (i_cmd.wr && i_cmd.acc == mcca_pkg::ACC_OWN);

    always_ff @(posedge i_clk) begin
        if (own_we) r_own_mem[own_addr] <= ~i_cmd.clr_step & i_cmd.wdata;
        r_own_q  <= r_own_mem[own_addr];
        r_rd_own <= (i_cmd.acc == mcca_pkg::ACC_OWN);
    end

    always_comb begin
        o_stat = '0;
        unique case (r_lvl)
            2'd0:    o_stat.rd_bit = r_free_q[0];
            2'd1:    o_stat.rd_bit = r_free_q[1];
            default: o_stat.rd_bit = r_free_q[2];
        endcase
        if (r_rd_own) o_stat.rd_bit = r_own_q;
        o_stat.bad           = (r_lvl >= nlev) || (32'(r_client) >= NUM_CLIENTS);
        o_stat.oob           = (r_color >> lg_l) != 8'd0;
        o_stat.c_last        = (r_c == lo_mask(lg_l));
        o_stat.j_last_fine   = (r_j == lo_mask(sh_fine));
        o_stat.j_last_coarse = (r_j == lo_mask(sh_coarse));
        o_stat.j_last_own    = (r_j == lo_mask(sh_own));
        o_stat.t_coarse      = (lg_t < lg_l);
        o_stat.t_zero        = (r_t == 2'd0);
        o_stat.t_top         = (r_t == nlev - 2'd1);
        o_stat.sweep_last    = (r_sweep == {OAW{1'b1}});
        o_stat.kind          = r_kind;
    end

    // result register
    logic [LM+7:0] c_ext;
    assign c_ext = {8'(0), r_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.res_set;
        end
        if (i_cmd.res_set) begin
            o_status       <= i_cmd.res_code;
            o_chosen_color <= (i_cmd.res_code == mcca_pkg::ST_DONE) ? c_ext[7:0] : 8'd0;
        end
    end

endmodule

// ===== hdl/mcca_ctrl.sv =====
// Controller: sequences the scans and range updates of one request.
module mcca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_start,
    input  mcca_pkg::t_dp_stat i_stat,
    output mcca_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    mcca_pkg::t_state  r_state, n_state;
    mcca_pkg::t_status fail_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mcca_pkg::S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_busy    = (r_state != mcca_pkg::S_IDLE);
    assign fail_code = i_stat.kind[1] ? mcca_pkg::ST_NOTHING : mcca_pkg::ST_NOFREE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (i_cfg_we) begin
            n_state = mcca_pkg::S_CLEAR;
        end else begin
            unique case (r_state)
                mcca_pkg::S_CLEAR: begin
                    o_cmd.clr_step = 1'b1;
                    if (i_stat.sweep_last) n_state = mcca_pkg::S_IDLE;
                end
                mcca_pkg::S_IDLE: begin
                    if (i_start) begin
                        o_cmd.load = 1'b1;
                        n_state    = mcca_pkg::S_CHECK;
                    end
                end
                mcca_pkg::S_CHECK: begin
                    if (i_stat.bad || (i_stat.kind[0] && i_stat.oob)) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = fail_code;
                        n_state        = mcca_pkg::S_IDLE;
                    end else begin
                        o_cmd.c_zero  = ~i_stat.kind[0];
                        o_cmd.c_color = i_stat.kind[0];
                        unique case (i_stat.kind)
                            mcca_pkg::KIND_ALLOC_ANY:  n_state = mcca_pkg::S_AA_RD;
                            mcca_pkg::KIND_ALLOC_SPEC: n_state = mcca_pkg::S_AS_RD;
                            mcca_pkg::KIND_FREE_ANY:   n_state = mcca_pkg::S_FA_RD;
                            default:                   n_state = mcca_pkg::S_FS_RD;
                        endcase
                    end
                end
                mcca_pkg::S_AA_RD, mcca_pkg::S_AS_RD,
                mcca_pkg::S_FA_RD, mcca_pkg::S_FS_RD: begin
                    o_cmd.acc = mcca_pkg::ACC_FREE_C;
                    o_cmd.j_clr = 1'b1;
                    unique case (r_state)
                        mcca_pkg::S_AA_RD: n_state = mcca_pkg::S_AA_EV;
                        mcca_pkg::S_AS_RD: n_state = mcca_pkg::S_AS_EV;
                        mcca_pkg::S_FA_RD: n_state = mcca_pkg::S_FA_EV;
                        default:           n_state = mcca_pkg::S_FS_EV;
                    endcase
                end
                mcca_pkg::S_AA_EV: begin
                    if (i_stat.rd_bit) begin
                        o_cmd.t_first_take = 1'b1;
                        n_state            = mcca_pkg::S_TK_LVL;
                    end else if (i_stat.c_last) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = fail_code;
                        n_state        = mcca_pkg::S_IDLE;
                    end else begin
                        o_cmd.c_inc = 1'b1;
                        n_state     = mcca_pkg::S_AA_RD;
                    end
                end
                mcca_pkg::S_AS_EV: begin
                    if (i_stat.rd_bit) begin
                        o_cmd.t_first_take = 1'b1;
                        n_state            = mcca_pkg::S_TK_LVL;
                    end else begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = fail_code;
                        n_state        = mcca_pkg::S_IDLE;
                    end
                end
                mcca_pkg::S_FA_EV: begin
                    if (!i_stat.rd_bit) begin
                        n_state = mcca_pkg::S_OWN_RD;
                    end else if (i_stat.c_last) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = fail_code;
                        n_state        = mcca_pkg::S_IDLE;
                    end else begin
                        o_cmd.c_inc = 1'b1;
                        n_state     = mcca_pkg::S_FA_RD;
                    end
                end
                mcca_pkg::S_FS_EV: begin
                    if (!i_stat.rd_bit) begin
                        n_state = mcca_pkg::S_OWN_RD;
                    end else begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = fail_code;
                        n_state        = mcca_pkg::S_IDLE;
                    end
                end
                mcca_pkg::S_OWN_RD: begin
                    o_cmd.acc = mcca_pkg::ACC_OWN;
                    n_state   = mcca_pkg::S_OWN_EV;
                end
                mcca_pkg::S_OWN_EV: begin
                    if (i_stat.rd_bit) begin
                        if (i_stat.j_last_own) begin
                            o_cmd.t_first_give = 1'b1;
                            o_cmd.j_clr        = 1'b1;
                            n_state            = mcca_pkg::S_GV_LVL;
                        end else begin
                            o_cmd.j_inc = 1'b1;
                            n_state     = mcca_pkg::S_OWN_RD;
                        end
                    end else if (i_stat.kind == mcca_pkg::KIND_FREE_ANY && !i_stat.c_last) begin
                        o_cmd.c_inc = 1'b1;
                        n_state     = mcca_pkg::S_FA_RD;
                    end else begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = fail_code;
                        n_state        = mcca_pkg::S_IDLE;
                    end
                end
                // take: clear every level, finer ones over their whole range
                mcca_pkg::S_TK_LVL: begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wdata = 1'b0;
                    o_cmd.acc   = i_stat.t_coarse ? mcca_pkg::ACC_FREE_COARSE
                                                  : mcca_pkg::ACC_FREE_FINE;
                    if (i_stat.t_coarse || i_stat.j_last_fine) begin
                        o_cmd.j_clr = 1'b1;
                        if (i_stat.t_top) n_state = mcca_pkg::S_TK_OWN;
                        else              o_cmd.t_inc = 1'b1;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                    end
                end
                mcca_pkg::S_TK_OWN: begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wdata = 1'b1;
                    o_cmd.acc   = mcca_pkg::ACC_OWN;
                    if (i_stat.j_last_own) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = mcca_pkg::ST_DONE;
                        n_state        = mcca_pkg::S_IDLE;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                    end
                end
                // give back: last level first; coarser bits need a full range
                mcca_pkg::S_GV_LVL: begin
                    if (i_stat.t_coarse) begin
                        n_state = mcca_pkg::S_GV_CHK_RD;
                    end else begin
                        o_cmd.wr    = 1'b1;
                        o_cmd.wdata = 1'b1;
                        o_cmd.acc   = mcca_pkg::ACC_FREE_FINE;
                        if (i_stat.j_last_fine) begin
                            o_cmd.j_clr = 1'b1;
                            if (i_stat.t_zero) n_state = mcca_pkg::S_GV_OWN;
                            else               o_cmd.t_dec = 1'b1;
                        end else begin
                            o_cmd.j_inc = 1'b1;
                        end
                    end
                end
                mcca_pkg::S_GV_CHK_RD: begin
                    o_cmd.acc = mcca_pkg::ACC_LVL_RANGE;
                    n_state   = mcca_pkg::S_GV_CHK_EV;
                end
                mcca_pkg::S_GV_CHK_EV: begin
                    if (!i_stat.rd_bit) begin
                        o_cmd.j_clr = 1'b1;
                        if (i_stat.t_zero) begin
                            n_state = mcca_pkg::S_GV_OWN;
                        end else begin
                            o_cmd.t_dec = 1'b1;
                            n_state     = mcca_pkg::S_GV_LVL;
                        end
                    end else if (i_stat.j_last_coarse) begin
                        n_state = mcca_pkg::S_GV_SET;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state     = mcca_pkg::S_GV_CHK_RD;
                    end
                end
                mcca_pkg::S_GV_SET: begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wdata = 1'b1;
                    o_cmd.acc   = mcca_pkg::ACC_FREE_COARSE;
                    o_cmd.j_clr = 1'b1;
                    if (i_stat.t_zero) begin
                        n_state = mcca_pkg::S_GV_OWN;
                    end else begin
                        o_cmd.t_dec = 1'b1;
                        n_state     = mcca_pkg::S_GV_LVL;
                    end
                end
                mcca_pkg::S_GV_OWN: begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.wdata = 1'b0;
                    o_cmd.acc   = mcca_pkg::ACC_OWN;
                    if (i_stat.j_last_own) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = mcca_pkg::ST_DONE;
                        n_state        = mcca_pkg::S_IDLE;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                    end
                end
                default: n_state = mcca_pkg::S_CLEAR;
            endcase
        end
    end

endmodule

// ===== hdl/multilevel_cache_color_allocator.sv =====
// Top level of the multilevel cache color allocator.
// Usage:
//  - Request channel: drive i_kind/i_level/i_color/i_client and raise start;
//    the word is taken at a clock edge where start is high and busy is low.
//  - Result channel: o_valid pulses for one cycle with o_status and
//    o_chosen_color; the receiver cannot stall, so take the word then.
//  - Config: i_cfg_we/i_cfg_index/i_cfg_data write one register per edge,
//    only while the block is idle. Any write refills all maps.
//  - Reset (synchronous, i_rst_n low) and every config write start a clear
//    pass over all 2**(clog2(NUM_CLIENTS)+floor(log2(MAX_COLORS))) map
//    addresses, 2048 at the defaults, during which busy stays high.
//  - Sequence: a bad level, bad client or, for the specific kinds, an
//    out-of-range color answers from the check state. Otherwise a check,
//    then scan steps of a read and an evaluate each, then the map bits are
//    written one at a time: each finer level's whole range, one bit per
//    coarser level, the owner range. Frees add a read and an evaluate per
//    owned bit checked and per bit of a coarser level's range check.
//  - One request is in flight at a time; the result shows in the first cycle
//    busy is low, and a new request may be taken in that same cycle.
module multilevel_cache_color_allocator #(
    parameter int MAX_COLORS  = mcca_pkg::MAX_COLORS,
    parameter int NUM_CLIENTS = mcca_pkg::NUM_CLIENTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [1:0]                  i_level,
    input  logic [7:0]                  i_color,
    input  logic [2:0]                  i_client,
    input  logic                        i_cfg_we,
    input  logic [mcca_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [mcca_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_chosen_color
);
    mcca_pkg::t_dp_cmd  cmd;
    mcca_pkg::t_dp_stat stat;

    // sequencer
    mcca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // maps, counters, config and result register
    mcca_dp #(
        .MAX_COLORS  (MAX_COLORS),
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_level        (i_level),
        .i_color        (i_color),
        .i_client       (i_client),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_chosen_color (o_chosen_color)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the multilevel cache color allocator.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 40000;   // cycles with no handshake at all
    localparam int MAX_COLORS  = mcca_pkg::MAX_COLORS;
    localparam int NUM_CLIENTS = mcca_pkg::NUM_CLIENTS;

    typedef struct {
        logic [1:0] kind;
        logic [1:0] level;
        logic [7:0] color;
        logic [2:0] client;
    } t_color_req;

    typedef struct {
        mcca_pkg::t_status status;
        logic [7:0]        color;
    } t_color_answer;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    i_kind = '0;
    logic [1:0]                    i_level = '0;
    logic [7:0]                    i_color = '0;
    logic [2:0]                    i_client = '0;
    logic                          i_cfg_we = 1'b0;
    logic [mcca_pkg::CFG_AW-1:0]   i_cfg_index = '0;
    logic [mcca_pkg::CFG_DW-1:0]   i_cfg_data = '0;
    logic                          o_valid;
    logic [1:0]                    o_status;
    logic [7:0]                    o_chosen_color;

    t_color_req    pending_reqs[$];
    t_color_answer expected_answers[$];
    int            words_sent = 0;
    int            fail_count = 0;
    int            quiet_cycles = 0;

    // Predictor state: our own copy of the color maps and registers.
    bit        free_map[3][MAX_COLORS];
    bit        owned_map[NUM_CLIENTS][MAX_COLORS];
    bit [1:0]  levels_reg;
    bit [3:0]  lg_reg[3];
    int        eff_lg[3];
    int        eff_levels;

    multilevel_cache_color_allocator dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic void clear_maps();
        foreach (free_map[t, c]) free_map[t][c] = 1'b1;
        foreach (owned_map[k, c]) owned_map[k][c] = 1'b0;
    endfunction

    // Effective level count and clamped log2 sizes.
    function automatic void resolve_sizes();
        eff_levels = (levels_reg == 2'd0) ? 1 : int'(levels_reg);
        for (int t = 0; t < 3; t++)
            eff_lg[t] = (lg_reg[t] > 4'd8) ? 8 : int'(lg_reg[t]);
        for (int t = 0; t + 1 < eff_levels; t++)
            if (eff_lg[t] > eff_lg[eff_levels-1]) eff_lg[t] = eff_lg[eff_levels-1];
    endfunction

    function automatic bit range_free(int t, int base, int n);
        for (int i = 0; i < n; i++) if (!free_map[t][base+i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit client_owns(int lvl, int c, int cl);
        int sh;
        sh = eff_lg[eff_levels-1] - eff_lg[lvl];
        for (int i = 0; i < (1 << sh); i++) if (!owned_map[cl][(c << sh) + i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void mark_taken(int lvl, int c, int cl);
        int sh;
        for (int t = 0; t < eff_levels; t++) begin
            if (eff_lg[t] >= eff_lg[lvl]) begin
                sh = eff_lg[t] - eff_lg[lvl];
                for (int i = 0; i < (1 << sh); i++) free_map[t][(c << sh) + i] = 1'b0;
            end else begin
                free_map[t][c >> (eff_lg[lvl] - eff_lg[t])] = 1'b0;
            end
        end
        sh = eff_lg[eff_levels-1] - eff_lg[lvl];
        for (int i = 0; i < (1 << sh); i++) owned_map[cl][(c << sh) + i] = 1'b1;
    endfunction

    // Coarser bits come back only once the whole finer range is free; levels
    // are walked top-down, so the order of updates matters.
    function automatic void mark_returned(int lvl, int c, int cl);
        int sh;
        int b;
        for (int t = eff_levels - 1; t >= 0; t--) begin
            if (eff_lg[t] >= eff_lg[lvl]) begin
                sh = eff_lg[t] - eff_lg[lvl];
                for (int i = 0; i < (1 << sh); i++) free_map[t][(c << sh) + i] = 1'b1;
            end else begin
                sh = eff_lg[lvl] - eff_lg[t];
                b = c >> sh;
                if (range_free(lvl, b << sh, 1 << sh)) free_map[t][b] = 1'b1;
            end
        end
        sh = eff_lg[eff_levels-1] - eff_lg[lvl];
        for (int i = 0; i < (1 << sh); i++) owned_map[cl][(c << sh) + i] = 1'b0;
    endfunction

    function automatic t_color_answer predict_color_answer(t_color_req r);
        t_color_answer a;
        int lvl;
        int cnt;
        int c;
        int col;
        int cl;
        lvl = int'(r.level);
        col = int'(r.color);
        cl  = int'(r.client);
        resolve_sizes();
        a.status = (r.kind == mcca_pkg::KIND_ALLOC_ANY || r.kind == mcca_pkg::KIND_ALLOC_SPEC)
                   ? mcca_pkg::ST_NOFREE : mcca_pkg::ST_NOTHING;
        a.color = '0;
        if (lvl >= eff_levels || cl >= NUM_CLIENTS) return a;
        cnt = 1 << eff_lg[lvl];
        case (r.kind)
            mcca_pkg::KIND_ALLOC_ANY: begin
                for (c = 0; c < cnt; c++) if (free_map[lvl][c]) break;
                if (c < cnt) begin
                    mark_taken(lvl, c, cl);
                    a.status = mcca_pkg::ST_DONE;
                    a.color = 8'(c);
                end
            end
            mcca_pkg::KIND_ALLOC_SPEC: begin
                if (col < cnt && free_map[lvl][col]) begin
                    mark_taken(lvl, col, cl);
                    a.status = mcca_pkg::ST_DONE;
                    a.color = r.color;
                end
            end
            mcca_pkg::KIND_FREE_ANY: begin
                for (c = 0; c < cnt; c++)
                    if (!free_map[lvl][c] && client_owns(lvl, c, cl)) break;
                if (c < cnt) begin
                    mark_returned(lvl, c, cl);
                    a.status = mcca_pkg::ST_DONE;
                    a.color = 8'(c);
                end
            end
            default: begin
                if (col < cnt && !free_map[lvl][col]
                        && client_owns(lvl, col, cl)) begin
                    mark_returned(lvl, col, cl);
                    a.status = mcca_pkg::ST_DONE;
                    a.color = r.color;
                end
            end
        endcase
        return a;
    endfunction

    // Idle roll: about 12 in 100, except for a calm stretch mid-run.
    function automatic bit hold_back();
        if (words_sent >= 300 && words_sent < 450) return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    // Request driver: a word leaves when start is high and busy is low.
    always @(posedge i_clk) begin
        t_color_req r;
        if (start && !busy) begin
            expected_answers.push_back(predict_color_answer(
                '{i_kind, i_level, i_color, i_client}));
            words_sent++;
        end
        if (start && busy) begin
            // hold the word until it is taken
        end else if (pending_reqs.size() > 0 && !hold_back()) begin
            r = pending_reqs.pop_front();
            start    <= 1'b1;
            i_kind   <= r.kind;
            i_level  <= r.level;
            i_color  <= r.color;
            i_client <= r.client;
        end else begin
            start <= 1'b0;
        end
    end

    // Result monitor plus watchdog.
    always @(posedge i_clk) begin
        t_color_answer e;
        if (o_valid) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected result word: status %0d color %0d",
                       o_status, o_chosen_color);
                fail_count++;
            end else begin
                e = expected_answers.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    fail_count++;
                end
                if (o_chosen_color !== e.color) begin
                    $error("chosen_color: expected %0d, got %0d", e.color, o_chosen_color);
                    fail_count++;
                end
            end
        end
        if (o_valid || (start && !busy) || i_cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("multilevel_cache_color_allocator: mismatch");
            $finish;
        end
    end

    task automatic queue_req(logic [1:0] k, logic [1:0] l, logic [7:0] c, logic [2:0] cl);
        pending_reqs.push_back('{k, l, c, cl});
    endtask

    // Block until every queued word went out and every answer came back.
    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_answers.size() > 0 || busy)
            @(posedge i_clk);
    endtask

    // One register write; the clear pass that follows keeps busy high.
    task automatic write_reg(logic [mcca_pkg::CFG_AW-1:0] idx,
                             logic [mcca_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mcca_pkg::REG_LEVELS) levels_reg = val[1:0];
        else lg_reg[idx - 2'd1] = val;
        clear_maps();
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int lv;
        int roll;
        int top;
        logic [1:0] k;
        logic [1:0] l;
        logic [7:0] c;
        resolve_sizes();
        lv = eff_levels;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            k = (roll < 30) ? mcca_pkg::KIND_ALLOC_ANY :
                (roll < 55) ? mcca_pkg::KIND_ALLOC_SPEC :
                (roll < 75) ? mcca_pkg::KIND_FREE_ANY : mcca_pkg::KIND_FREE_SPEC;
            l = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                            : 2'($urandom_range(0, lv - 1));
            top = (l < 2'd3) ? (1 << eff_lg[l]) - 1 : 0;
            c = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, top));
            queue_req(k, l, c, 3'($urandom_range(0, 7)));
        end
        drain();
    endtask

    initial begin
        levels_reg = 2'd3;
        lg_reg[0]  = 4'd3;
        lg_reg[1]  = 4'd5;
        lg_reg[2]  = 4'd7;
        clear_maps();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset sizes 8/32/128 colors.
        queue_req(mcca_pkg::KIND_ALLOC_ANY,  2'd0, 8'd0,   3'd0);  // first free color
        queue_req(mcca_pkg::KIND_ALLOC_SPEC, 2'd2, 8'd127, 3'd7);  // top color, top client
        queue_req(mcca_pkg::KIND_ALLOC_SPEC, 2'd2, 8'd127, 3'd1);  // already taken
        queue_req(mcca_pkg::KIND_ALLOC_SPEC, 2'd0, 8'd255, 3'd0);  // color out of range
        queue_req(mcca_pkg::KIND_ALLOC_ANY,  2'd3, 8'd0,   3'd0);  // absent level
        queue_req(mcca_pkg::KIND_FREE_SPEC,  2'd2, 8'd127, 3'd2);  // foreign free
        queue_req(mcca_pkg::KIND_FREE_SPEC,  2'd2, 8'd127, 3'd7);  // owner frees
        queue_req(mcca_pkg::KIND_FREE_SPEC,  2'd1, 8'd200, 3'd0);  // free out of range
        queue_req(mcca_pkg::KIND_FREE_ANY,   2'd3, 8'd0,   3'd0);  // free on absent level
        queue_req(mcca_pkg::KIND_ALLOC_SPEC, 2'd1, 8'd31,  3'd3);
        queue_req(mcca_pkg::KIND_ALLOC_ANY,  2'd2, 8'd0,   3'd3);
        queue_req(mcca_pkg::KIND_ALLOC_ANY,  2'd1, 8'd0,   3'd4);
        queue_req(mcca_pkg::KIND_FREE_ANY,   2'd2, 8'd0,   3'd3);  // coarse bit stays held
        queue_req(mcca_pkg::KIND_FREE_ANY,   2'd1, 8'd0,   3'd3);
        queue_req(mcca_pkg::KIND_FREE_ANY,   2'd1, 8'd0,   3'd3);
        queue_req(mcca_pkg::KIND_FREE_ANY,   2'd0, 8'd0,   3'd5);  // nothing owned
        queue_req(mcca_pkg::KIND_FREE_SPEC,  2'd0, 8'd0,   3'd0);
        queue_req(mcca_pkg::KIND_FREE_ANY,   2'd1, 8'd0,   3'd4);
        queue_req(mcca_pkg::KIND_ALLOC_SPEC, 2'd0, 8'd7,   3'd6);
        queue_req(mcca_pkg::KIND_FREE_SPEC,  2'd0, 8'd7,   3'd6);
        drain();
        random_phase(110);

        // Single level (zero acts as one), oversized and tiny counts.
        write_reg(mcca_pkg::REG_LEVELS, 4'd0);
        write_reg(mcca_pkg::REG_LG1, 4'd15);
        write_reg(mcca_pkg::REG_LG2, 4'd0);
        write_reg(mcca_pkg::REG_LG3, 4'd8);
        random_phase(100);

        write_reg(mcca_pkg::REG_LEVELS, 4'd2);
        write_reg(mcca_pkg::REG_LG1, 4'd8);   // clamped to level two's count
        write_reg(mcca_pkg::REG_LG2, 4'd4);
        random_phase(110);

        write_reg(mcca_pkg::REG_LEVELS, 4'd3);
        write_reg(mcca_pkg::REG_LG1, 4'd0);
        write_reg(mcca_pkg::REG_LG2, 4'd0);
        write_reg(mcca_pkg::REG_LG3, 4'd0);
        random_phase(60);

        write_reg(mcca_pkg::REG_LG1, 4'd8);
        write_reg(mcca_pkg::REG_LG2, 4'd8);
        write_reg(mcca_pkg::REG_LG3, 4'd8);
        random_phase(140);

        write_reg(mcca_pkg::REG_LG1, 4'd2);
        write_reg(mcca_pkg::REG_LG2, 4'd15);
        random_phase(110);

        write_reg(mcca_pkg::REG_LEVELS, 4'd1);
        write_reg(mcca_pkg::REG_LG1, 4'd6);
        random_phase(90);

        write_reg(mcca_pkg::REG_LEVELS, 4'd2);
        write_reg(mcca_pkg::REG_LG1, 4'd1);
        write_reg(mcca_pkg::REG_LG2, 4'd7);
        write_reg(mcca_pkg::REG_LG3, 4'd3);
        random_phase(110);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("multilevel_cache_color_allocator: match");
        end else begin
            $display("multilevel_cache_color_allocator: mismatch");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/mcca_pkg.sv
hdl/mcca_dp.sv
hdl/mcca_ctrl.sv
hdl/multilevel_cache_color_allocator.sv
bench/testbench.sv
